// ===== sv/crk_pkg.sv =====
// ----------------------------------------------------------------------------
// crk_pkg
// Shared types and constants of the keyframe track interpolator.
// ----------------------------------------------------------------------------
package crk_pkg;

    localparam int KEY_WORDS = 6;
    localparam int COORD_W   = 32;
    localparam int PHASE_W   = 17;
    localparam int H_W       = 38;
    localparam int T_W       = PHASE_W + 1;
    localparam int P_W       = H_W + T_W;

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(65536);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic signed [H_W-1:0] SAT_HI = H_W'(64'sd2147483647);
    localparam logic signed [H_W-1:0] SAT_LO = H_W'(-64'sd2147483648);

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic       start;
        logic [2:0] tag;
    } hz_cmd_t;

    typedef struct packed {
        logic       ready;
        logic       done;
        logic [2:0] tag;
    } hz_sts_t;

endpackage

// ===== sv/crk_ram.sv =====
// ----------------------------------------------------------------------------
// crk_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module crk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 96,
    parameter int AW    = 7
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/crk_phase_div.sv =====
// ----------------------------------------------------------------------------
// crk_phase_div
// Turns elapsed milliseconds into a rounded Q16.16 phase step by multiplying
// with the reciprocal of the segment length, in two partial products.
// ----------------------------------------------------------------------------
module crk_phase_div #(
    parameter int SEGMENT_MS = 3000
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] elapsed_ms,
    output logic        done,
    output logic [31:0] step
);

    // The numerator stays below 2^32, so a 33-bit reciprocal rounded up
    // gives the exact floor for every input.
    localparam int          SH    = $clog2(SEGMENT_MS);
    localparam logic [63:0] RECIP = ((64'd1 << (32 + SH)) + 64'(SEGMENT_MS) - 64'd1)
                                    / 64'(SEGMENT_MS);
    localparam logic [16:0] M_LO  = RECIP[16:0];
    localparam logic [15:0] M_HI  = RECIP[32:17];
    localparam logic [31:0] HALF  = 32'(SEGMENT_MS / 2);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_LO   = 3'b010,
        D_HI   = 3'b100
    } div_state_t;

    div_state_t  state_reg;
    div_state_t  state_next;
    logic [31:0] num_reg;
    logic [64:0] acc_reg;
    logic [48:0] prod_lo;
    logic [47:0] prod_hi;

    assign prod_lo = {17'b0, num_reg} * {32'b0, M_LO};
    assign prod_hi = {16'b0, num_reg} * {32'b0, M_HI};

    always_comb
    begin
        case (state_reg)
            D_IDLE:  state_next = D_IDLE;
            D_LO:    state_next = D_HI;
            D_HI:    state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
        if (start)
        begin
            state_next = D_LO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {elapsed_ms, 16'b0} + HALF;
        end
        case (state_reg)
            D_LO:    acc_reg <= 65'(prod_lo);
            D_HI:    acc_reg <= acc_reg + {prod_hi, 17'b0};
            default:
            begin
            end
        endcase
    end

    assign done = (state_reg == D_IDLE);
    assign step = 32'(acc_reg >> (32 + SH));

endmodule

// ===== sv/crk_horner.sv =====
// ----------------------------------------------------------------------------
// crk_horner
// One Catmull-Rom cubic evaluated by Horner steps on a shared multiplier,
// with Q16.16 rounding, a final halving and signed 32-bit saturation.
// ----------------------------------------------------------------------------
module crk_horner (
    input  logic                   clk,
    input  logic                   rst_n,
    input  crk_pkg::hz_cmd_t       cmd,
    input  crk_pkg::coord_t        p [4],
    input  logic [16:0]            t,
    output crk_pkg::hz_sts_t       sts,
    output crk_pkg::coord_t        res
);

    import crk_pkg::*;

    typedef enum logic [7:0] {
        H_IDLE = 8'b00000001,
        H_M1   = 8'b00000010,
        H_A1   = 8'b00000100,
        H_M2   = 8'b00001000,
        H_A2   = 8'b00010000,
        H_M3   = 8'b00100000,
        H_A3   = 8'b01000000,
        H_SAT  = 8'b10000000
    } hz_state_t;

    localparam logic signed [P_W-1:0] RND_HALF = P_W'(32768);

    hz_state_t state_reg;
    hz_state_t state_next;

    logic signed [H_W-1:0] e [4];
    logic signed [H_W-1:0] coef_a;
    logic signed [H_W-1:0] coef_b;
    logic signed [H_W-1:0] coef_c;
    logic signed [H_W-1:0] coef_d;
    logic signed [T_W-1:0] t_s;
    logic signed [P_W-1:0] mul;
    logic signed [P_W-1:0] rnd_full;
    logic signed [H_W-1:0] rnd;
    logic signed [H_W-1:0] half;

    logic signed [H_W-1:0] m_reg;
    logic signed [H_W-1:0] b_reg;
    logic signed [H_W-1:0] c_reg;
    logic signed [H_W-1:0] d_reg;
    logic signed [P_W-1:0] prod_reg;
    logic [2:0]            tag_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            e[i] = H_W'(p[i]);
        end
    end

    assign coef_a = e[3] - e[0] + (e[1] + (e[1] <<< 1)) - (e[2] + (e[2] <<< 1));
    assign coef_b = (e[0] <<< 1) - (e[1] + (e[1] <<< 2)) + (e[2] <<< 2) - e[3];
    assign coef_c = e[2] - e[0];
    assign coef_d = e[1] <<< 1;

    assign t_s      = $signed({1'b0, t});
    assign mul      = P_W'(m_reg) * P_W'(t_s);
    assign rnd_full = (prod_reg + RND_HALF) >>> 16;
    assign rnd      = H_W'(rnd_full);
    assign half     = (m_reg + H_W'(1)) >>> 1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            H_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = H_M1;
                end
            end
            H_M1:    state_next = H_A1;
            H_A1:    state_next = H_M2;
            H_M2:    state_next = H_A2;
            H_A2:    state_next = H_M3;
            H_M3:    state_next = H_A3;
            H_A3:    state_next = H_SAT;
            H_SAT:   state_next = H_IDLE;
            default: state_next = H_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            H_IDLE:
            begin
                if (cmd.start)
                begin
                    m_reg   <= coef_a;
                    b_reg   <= coef_b;
                    c_reg   <= coef_c;
                    d_reg   <= coef_d;
                    tag_reg <= cmd.tag;
                end
            end
            H_M1, H_M2, H_M3:
            begin
                prod_reg <= mul;
            end
            H_A1:    m_reg <= rnd + b_reg;
            H_A2:    m_reg <= rnd + c_reg;
            H_A3:    m_reg <= rnd + d_reg;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (half > SAT_HI)
        begin
            res = coord_t'(32'sh7FFFFFFF);
        end
        else if (half < SAT_LO)
        begin
            res = coord_t'(32'sh80000000);
        end
        else
        begin
            res = coord_t'(half[COORD_W-1:0]);
        end
    end

    assign sts.ready = (state_reg == H_IDLE);
    assign sts.done  = (state_reg == H_SAT);
    assign sts.tag   = tag_reg;

endmodule

// ===== sv/catmull_rom_keyframe_track.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_keyframe_track
// Keyframe track interpolator: a key table in RAM, a Catmull-Rom evaluator
// on one shared multiplier, and a phase and segment tracker.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid, in_stall   | req_type, key_index, key_*, elapsed_ms
//  out      | out_valid, out_stall | out_pos_*, out_look_*, out_segment
//  cfg      | cfg_valid, cfg_ready | cfg_data (key_count)
//
//  A load transfer is accepted, then written to the RAM as six words.
//  A tick transfer is accepted and reads the first four keys, then runs six
//  cubics on the shared multiplier with the key reads for the next cubic
//  overlapped, then updates the phase and loads the output.
//  The key table is not cleared by reset and must be loaded before use.
//  A held result stalls the block only when the next tick has finished too.
// ----------------------------------------------------------------------------
module catmull_rom_keyframe_track #(
    parameter int MAX_KEYS   = 16,
    parameter int SEGMENT_MS = 3000
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [4:0]      cfg_data,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            req_type,
    input  logic [3:0]      key_index,
    input  crk_pkg::coord_t key_pos_x,
    input  crk_pkg::coord_t key_pos_y,
    input  crk_pkg::coord_t key_pos_z,
    input  crk_pkg::coord_t key_look_x,
    input  crk_pkg::coord_t key_look_y,
    input  crk_pkg::coord_t key_look_z,
    input  logic [15:0]     elapsed_ms,
    output logic            out_valid,
    input  logic            out_stall,
    output crk_pkg::coord_t out_pos_x,
    output crk_pkg::coord_t out_pos_y,
    output crk_pkg::coord_t out_pos_z,
    output crk_pkg::coord_t out_look_x,
    output crk_pkg::coord_t out_look_y,
    output crk_pkg::coord_t out_look_z,
    output logic [3:0]      out_segment
);

    import crk_pkg::*;

    localparam int DEPTH = MAX_KEYS * KEY_WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NCAP  = (MAX_KEYS < 16) ? MAX_KEYS : 16;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_CAPT  = 7'b0001000,
        ST_START = 7'b0010000,
        ST_WAIT  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [4:0]         key_count_reg;
    logic [3:0]         segment_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [2:0]         fj_reg;
    logic [1:0]         q_reg;
    logic               rd_pend_reg;
    logic [1:0]         rd_q_reg;
    logic               out_valid_reg;

    logic [3:0]         slot_reg;
    logic [3:0]         seg_cur_reg;
    logic [4:0]         n_cur_reg;
    logic [PHASE_W-1:0] t_reg;
    coord_t             ld_word_reg [KEY_WORDS];
    coord_t             p_reg [4];
    coord_t             res_reg [KEY_WORDS];
    coord_t             out_word_reg [KEY_WORDS];
    logic [3:0]         out_seg_reg;

    logic               in_xfer;
    logic               load_ok;
    logic [4:0]         n_eff;
    logic [3:0]         seg_eff;
    logic [4:0]         seg_inc;
    logic [32:0]        phase_sum;
    logic               out_load;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [COORD_W-1:0] ram_rdata;

    hz_cmd_t            hz_cmd;
    hz_sts_t            hz_sts;
    coord_t             hz_res;

    logic               div_start;
    logic               div_done;
    logic [31:0]        div_step;

    function automatic logic [AW-1:0] word_addr(logic [3:0] slot, logic [2:0] w);
        return AW'(slot) * AW'(KEY_WORDS) + AW'(w);
    endfunction

    function automatic logic [3:0] key_slot(logic [3:0] seg, logic [4:0] n, logic [1:0] q);
        logic signed [6:0] v;
        logic signed [6:0] ns;
        ns = $signed({2'b0, n});
        v  = $signed({3'b0, seg}) + $signed({5'b0, q}) - 7'sd2;
        if (v < 7'sd0)
        begin
            v = v + ns;
        end
        if (v < 7'sd0)
        begin
            v = v + ns;
        end
        if (v >= ns)
        begin
            v = v - ns;
        end
        return v[3:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign load_ok   = (int'(key_index) < MAX_KEYS);

    always_comb
    begin
        n_eff = key_count_reg;
        if (n_eff > 5'(NCAP))
        begin
            n_eff = 5'(NCAP);
        end
        if (n_eff == 5'd0)
        begin
            n_eff = 5'd1;
        end
    end

    assign seg_eff   = ({1'b0, segment_reg} >= n_eff) ? 4'd0 : segment_reg;
    assign seg_inc   = {1'b0, seg_cur_reg} + 5'd1;
    assign phase_sum = 33'(t_reg) + 33'(div_step);
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    assign hz_cmd.start = (state_reg == ST_START) && hz_sts.ready;
    assign hz_cmd.tag   = fj_reg;
    assign div_start    = in_xfer && (req_type == REQ_TICK);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (req_type == REQ_TICK)
                    begin
                        state_next = ST_READ;
                    end
                    else if (load_ok)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                if (fj_reg == 3'(KEY_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (q_reg == 2'd3)
                begin
                    state_next = ST_CAPT;
                end
            end
            ST_CAPT: state_next = ST_START;
            ST_START:
            begin
                if (hz_sts.ready)
                begin
                    state_next = (fj_reg == 3'(KEY_WORDS - 1)) ? ST_WAIT : ST_READ;
                end
            end
            ST_WAIT:
            begin
                if (hz_sts.ready && div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_count_reg <= 5'd4;
            segment_reg   <= '0;
            phase_reg     <= '0;
            fj_reg        <= '0;
            q_reg         <= '0;
            rd_pend_reg   <= 1'b0;
            rd_q_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_READ);
            rd_q_reg    <= q_reg;
            if (cfg_valid && cfg_ready)
            begin
                key_count_reg <= cfg_data;
            end
            if (in_xfer)
            begin
                fj_reg <= '0;
                q_reg  <= '0;
            end
            case (state_reg)
                ST_LOAD: fj_reg <= fj_reg + 3'd1;
                ST_READ: q_reg  <= q_reg + 2'd1;
                ST_START:
                begin
                    if (hz_sts.ready)
                    begin
                        fj_reg <= fj_reg + 3'd1;
                        q_reg  <= '0;
                    end
                end
                ST_WAIT:
                begin
                    if (hz_sts.ready && div_done)
                    begin
                        if (phase_sum > 33'(PHASE_ONE))
                        begin
                            segment_reg <= (seg_inc >= n_cur_reg) ? 4'd0 : seg_inc[3:0];
                            phase_reg   <= '0;
                        end
                        else
                        begin
                            segment_reg <= seg_cur_reg;
                            phase_reg   <= phase_sum[PHASE_W-1:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            slot_reg       <= key_index;
            seg_cur_reg    <= seg_eff;
            n_cur_reg      <= n_eff;
            t_reg          <= phase_reg;
            ld_word_reg[0] <= key_pos_x;
            ld_word_reg[1] <= key_pos_y;
            ld_word_reg[2] <= key_pos_z;
            ld_word_reg[3] <= key_look_x;
            ld_word_reg[4] <= key_look_y;
            ld_word_reg[5] <= key_look_z;
        end
        if (rd_pend_reg)
        begin
            p_reg[rd_q_reg] <= coord_t'(ram_rdata);
        end
        if (hz_sts.done)
        begin
            res_reg[hz_sts.tag] <= hz_res;
        end
        if (out_load)
        begin
            out_word_reg <= res_reg;
            out_seg_reg  <= seg_cur_reg;
        end
    end

    assign ram_we    = (state_reg == ST_LOAD);
    assign ram_waddr = word_addr(slot_reg, fj_reg);
    assign ram_raddr = word_addr(key_slot(seg_cur_reg, n_cur_reg, q_reg), fj_reg);

    crk_ram #(
        .WIDTH (COORD_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ld_word_reg[fj_reg]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    crk_horner u_horner (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (hz_cmd),
        .p     (p_reg),
        .t     (t_reg),
        .sts   (hz_sts),
        .res   (hz_res)
    );

    crk_phase_div #(
        .SEGMENT_MS (SEGMENT_MS)
    ) u_phase_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .elapsed_ms (elapsed_ms),
        .done       (div_done),
        .step       (div_step)
    );

    assign out_valid   = out_valid_reg;
    assign out_pos_x   = out_word_reg[0];
    assign out_pos_y   = out_word_reg[1];
    assign out_pos_z   = out_word_reg[2];
    assign out_look_x  = out_word_reg[3];
    assign out_look_y  = out_word_reg[4];
    assign out_look_z  = out_word_reg[5];
    assign out_segment = out_seg_reg;

endmodule
